// ===== rtl/wpsd_pkg.sv =====
package wpsd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_IDLE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_RIFF      = 3'd0,
        ERR_WAVE      = 3'd1,
        ERR_FMT_TAG   = 3'd2,
        ERR_FMT_SIZE  = 3'd3,
        ERR_NOT_PCM   = 3'd4,
        ERR_CHANNELS  = 3'd5,
        ERR_DATA_TAG  = 3'd6
    } t_err;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample;
        logic        last_sample;
        logic [2:0]  error_code;
        logic [31:0] sample_rate;
        logic [1:0]  channel_count;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
    } t_result;

endpackage

// ===== rtl/wpsd_parser.sv =====
module wpsd_parser
    import wpsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_res_valid,
    output t_result     o_res
);

    // header byte positions at which a field completes
    localparam logic [5:0] IX_RIFF     = 6'd3;
    localparam logic [5:0] IX_WAVE     = 6'd11;
    localparam logic [5:0] IX_FMT_TAG  = 6'd15;
    localparam logic [5:0] IX_FMT_SIZE = 6'd19;
    localparam logic [5:0] IX_FORMAT   = 6'd21;
    localparam logic [5:0] IX_CHANNELS = 6'd23;
    localparam logic [5:0] IX_RATE     = 6'd27;
    localparam logic [5:0] IX_BITS     = 6'd35;
    localparam logic [5:0] IX_DATA_TAG = 6'd39;
    localparam logic [5:0] IX_LENGTH   = 6'd43;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_SIZE = 32'd16;

    t_phase      r_phase,  n_phase;
    logic [5:0]  r_idx,    n_idx;
    logic [31:0] r_shift,  n_shift;
    logic [1:0]  r_ch,     n_ch;
    logic [15:0] r_bits,   n_bits;
    logic [31:0] r_rate,   n_rate;
    logic [31:0] r_rem,    n_rem;
    logic [1:0]  r_fbi,    n_fbi;

    t_phase      ph;
    logic [5:0]  idx;
    logic [31:0] shift_cur;
    logic [1:0]  fbi;
    logic [31:0] shifted;
    logic [15:0] v16;
    logic        eight;
    logic [2:0]  frame_len;
    logic [2:0]  fbi_inc;
    logic [31:0] rem_dec;

    always_comb begin
        // file_start restarts parsing with this byte as byte 0
        ph        = i_file_start ? PH_HEADER : r_phase;
        idx       = i_file_start ? 6'd0 : r_idx;
        shift_cur = i_file_start ? 32'd0 : r_shift;
        fbi       = i_file_start ? 2'd0 : r_fbi;

        shifted   = {i_data_byte, shift_cur[31:8]};
        v16       = shifted[31:16];
        eight     = (r_bits == 16'd8);
        frame_len = eight ? {1'b0, r_ch} : {r_ch, 1'b0};
        fbi_inc   = {1'b0, fbi} + 3'd1;
        rem_dec   = r_rem - 32'd1;

        n_phase = ph;
        n_idx   = idx;
        n_shift = shift_cur;
        n_ch    = r_ch;
        n_bits  = r_bits;
        n_rate  = r_rate;
        n_rem   = r_rem;
        n_fbi   = fbi;

        o_res_valid = 1'b0;
        o_res       = '0;

        case (ph)
            PH_HEADER: begin
                n_shift = shifted;
                n_idx   = idx + 6'd1;
                case (idx)
                    IX_RIFF: begin
                        if (shifted != TAG_RIFF) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_RIFF;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_WAVE: begin
                        if (shifted != TAG_WAVE) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_WAVE;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_FMT_TAG: begin
                        if (shifted != TAG_FMT) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_FMT_TAG;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_FMT_SIZE: begin
                        if (shifted != FMT_SIZE) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_FMT_SIZE;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_FORMAT: begin
                        if (v16 != 16'd1) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_NOT_PCM;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_CHANNELS: begin
                        if (v16 != 16'd1 && v16 != 16'd2) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_CHANNELS;
                            n_phase          = PH_IDLE;
                        end else begin
                            n_ch = v16[1:0];
                        end
                    end
                    IX_RATE: begin
                        n_rate = shifted;
                    end
                    IX_BITS: begin
                        n_bits = v16;
                    end
                    IX_DATA_TAG: begin
                        if (shifted != TAG_DATA) begin
                            o_res_valid     = 1'b1;
                            o_res.kind       = KIND_REJECT;
                            o_res.error_code = ERR_DATA_TAG;
                            n_phase          = PH_IDLE;
                        end
                    end
                    IX_LENGTH: begin
                        n_rem                 = shifted;
                        n_fbi                 = 2'd0;
                        n_phase               = PH_DATA;
                        o_res_valid           = 1'b1;
                        o_res.kind            = KIND_ACCEPT;
                        o_res.sample_rate     = r_rate;
                        o_res.channel_count   = r_ch;
                        o_res.bits_per_sample = r_bits;
                        o_res.data_length     = shifted;
                    end
                    default: begin
                    end
                endcase
            end
            PH_DATA: begin
                if (fbi == 2'd0 &&
                    (frame_len == 3'd0 || r_rem < {29'd0, frame_len})) begin
                    // partial final frame or empty frame: stop
                    n_phase = PH_IDLE;
                end else begin
                    if (eight && fbi == 2'd0) begin
                        n_shift = {24'd0, i_data_byte ^ 8'h80};
                    end else if (!eight && fbi == 2'd1) begin
                        n_shift = {24'd0, i_data_byte};
                    end
                    n_rem = rem_dec;
                    if (fbi_inc < frame_len) begin
                        n_fbi = fbi_inc[1:0];
                    end else begin
                        n_fbi        = 2'd0;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_SAMPLE;
                        o_res.sample = n_shift[7:0];
                        if (rem_dec < {29'd0, frame_len}) begin
                            o_res.last_sample = 1'b1;
                            n_phase           = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= 6'd0;
            r_shift <= 32'd0;
            r_ch    <= 2'd0;
            r_bits  <= 16'd0;
            r_rate  <= 32'd0;
            r_rem   <= 32'd0;
            r_fbi   <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_ch    <= n_ch;
            r_bits  <= n_bits;
            r_rate  <= n_rate;
            r_rem   <= n_rem;
            r_fbi   <= n_fbi;
        end
    end

endmodule

// ===== rtl/wpsd_out_reg.sv =====
module wpsd_out_reg
    import wpsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    // free when empty or the held item leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/wav_pcm_stream_decoder.sv =====
// Accepted items pass the input register, then the parser, then the result
// register, which drives o_valid. Throughput: one byte item per cycle while no
// stall holds them; the parse step between the registers is one shift/compare pass.
// Reset (i_rst_n low, synchronous): parser returns to header phase with all
// counters and held header fields cleared; both stage registers empty.
module wav_pcm_stream_decoder
    import wpsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_file_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [7:0]  o_sample,
    output logic               o_last_sample,
    output logic [2:0]         o_error_code,
    output logic [31:0]        o_sample_rate,
    output logic [1:0]         o_channel_count,
    output logic [15:0]        o_bits_per_sample,
    output logic [31:0]        o_data_length
);

    // input stage: one item of buffering ahead of the parser
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic       res_valid;
    t_result    res;
    logic       out_ready;
    logic       advance;
    logic       in_load;
    t_result    out_res;

    // An item that makes no result moves on even when the output is full;
    // one that makes a result waits for a free result register.
    assign advance = r_in_valid && (!res_valid || out_ready);
    assign o_stall = r_in_valid && !advance;
    assign in_load = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_file_start;
        end
    end

    // header checks and sample extraction, state updated per item
    wpsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_data_byte  (r_in_byte),
        .i_file_start (r_in_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register, doubles as the skid stage toward the consumer
    wpsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind            = out_res.kind;
    assign o_sample          = $signed(out_res.sample);
    assign o_last_sample     = out_res.last_sample;
    assign o_error_code      = out_res.error_code;
    assign o_sample_rate     = out_res.sample_rate;
    assign o_channel_count   = out_res.channel_count;
    assign o_bits_per_sample = out_res.bits_per_sample;
    assign o_data_length     = out_res.data_length;

endmodule
